[rtl/fha_pkg.sv]
// Package for the flow harmonic accumulator: sizes, widths, CORDIC angle table
// and the rounding and saturation helpers. No dependencies.
package fha_pkg;

    localparam int NUM_BINS      = 32;
    localparam int NUM_HARMONICS = 6;
    localparam int NUM_SPECIES   = 16;

    localparam int PT_W   = 24;
    localparam int SP_W   = 4;
    localparam int BIN_W  = 5;
    localparam int HARM_W = 3;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 40;
    localparam int Q_W    = 16;
    localparam int SQ_W   = 2 * PT_W;

    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 44;
    localparam int Z_W          = 32;

    localparam int CNT_DEPTH = NUM_SPECIES * NUM_BINS;
    localparam int SUM_DEPTH = NUM_HARMONICS * NUM_SPECIES * NUM_BINS;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int SUM_AW    = $clog2(SUM_DEPTH);
    localparam int H_W       = $clog2(NUM_HARMONICS + 1);

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    // Angle of step i in units of 2^-32 turn.
    function automatic logic [Z_W-1:0] turn_angle(input logic [STEP_W-1:0] i);
        logic [Z_W-1:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Round a CORDIC output to Q1.15 (half up), negate if asked, then clamp.
    function automatic logic signed [Q_W-1:0] to_q15(input logic signed [XY_W-1:0] v,
                                                     input logic neg);
        logic signed [XY_W-1:0] r;
        r = (v + XY_W'(16384)) >>> 15;
        if (neg) begin
            r = -r;
        end
        if (r > XY_W'(32767)) begin
            r = XY_W'(32767);
        end else if (r < -XY_W'(32768)) begin
            r = -XY_W'(32768);
        end
        return r[Q_W-1:0];
    endfunction

    // Saturating accumulate into a 40-bit sum.
    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [Q_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

[rtl/fha_cordic.sv]
// Shared CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on fha_pkg.
module fha_cordic (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fha_pkg::cordic_cmd_t               cmd,
    input  logic signed [fha_pkg::XY_W-1:0]    x_in,
    input  logic signed [fha_pkg::XY_W-1:0]    y_in,
    input  logic        [fha_pkg::Z_W-1:0]     z_in,
    output logic                               done,
    output logic signed [fha_pkg::XY_W-1:0]    x_out,
    output logic signed [fha_pkg::XY_W-1:0]    y_out,
    output logic        [fha_pkg::Z_W-1:0]     z_out
);
    import fha_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic                     vec_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [XY_W-1:0]   x_reg;
    logic signed [XY_W-1:0]   y_reg;
    logic [Z_W-1:0]           z_reg;
    logic                     sigma;
    logic signed [XY_W-1:0]   xs;
    logic signed [XY_W-1:0]   ys;

    // Vectoring drives y toward zero, rotation drives z toward zero.
    assign sigma = vec_reg ? (y_reg[XY_W-1] || (y_reg == '0)) : !z_reg[Z_W-1];
    assign xs    = x_reg >>> step_reg;
    assign ys    = y_reg >>> step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            vec_reg <= cmd.vectoring;
            x_reg   <= x_in;
            y_reg   <= y_in;
            z_reg   <= z_in;
        end else if (busy_reg) begin
            if (sigma) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - turn_angle(step_reg);
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + turn_angle(step_reg);
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[rtl/flow_harmonic_accumulator_unit.sv]
// Flow harmonic accumulator: per species and momentum bin, counts samples and sums cos/sin.
// A read reads the stores and then loads the output register, with zero values if refused; a
// sample outside the bins goes to the output after the range check, and a sample in range
// passes squaring, square root, range check, bin division, azimuth CORDIC, per harmonic a
// CORDIC run and a read-modify-write, then the output. A new item is taken only when idle.
// Reset clears the stores in a pass over 3072 addresses during which no input is taken.
module flow_harmonic_accumulator_unit (
    input  logic          aclk,
    input  logic          aresetn,
    // Input item. tdata from bit 0: species[3:0], px[27:4], py[51:28],
    // read_bin[56:52], read_harmonic[59:57], zero fill [63:60].
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic          s_tuser,    // func: 0 sample, 1 read
    // Result item. tdata from bit 0: bin[4:0], count[36:5], real_sum[76:37],
    // imag_sum[116:77], zero fill [119:117].
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [119:0]  m_tdata,
    output logic          m_tuser,    // in_range
    // Configuration port.
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import fha_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_SQY   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DCHK  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_VEC   = 4'd7;
    localparam logic [3:0] S_VWAIT = 4'd8;
    localparam logic [3:0] S_HROT  = 4'd9;
    localparam logic [3:0] S_HWAIT = 4'd10;
    localparam logic [3:0] S_HRD   = 4'd11;
    localparam logic [3:0] S_HWR   = 4'd12;
    localparam logic [3:0] S_RRD   = 4'd13;
    localparam logic [3:0] S_RWR   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    localparam logic REG_PT_MIN    = 1'b0;
    localparam logic REG_BIN_WIDTH = 1'b1;

    localparam int SQRT_W = $clog2(PT_W + 1);
    localparam int REM_W  = PT_W + 2;
    localparam int DIV_W  = PT_W + BIN_W;
    localparam int BD_W   = $clog2(BIN_W);

    // Configuration registers.
    logic [PT_W-1:0] pt_min_reg;
    logic [PT_W-1:0] bin_width_reg;

    // Sequencer and item registers.
    logic [3:0]               state_reg;
    logic [SUM_AW-1:0]        clr_reg;
    logic                     func_reg;
    logic [SP_W-1:0]          sp_reg;
    logic signed [PT_W-1:0]   px_reg;
    logic signed [PT_W-1:0]   py_reg;
    logic [BIN_W-1:0]         rb_reg;
    logic [HARM_W-1:0]        rh_reg;

    // Square root, division and angle registers.
    logic [SQ_W-1:0]          rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [PT_W-1:0]          root_reg;
    logic [SQRT_W-1:0]        iter_reg;
    logic [PT_W-1:0]          dvd_reg;
    logic [BIN_W-1:0]         quo_reg;
    logic [BD_W-1:0]          div_cnt_reg;
    logic [Q_W-1:0]           phi_reg;
    logic [Q_W-1:0]           ang_reg;
    logic                     neg_reg;
    logic [H_W-1:0]           h_reg;
    logic signed [Q_W-1:0]    cq_reg;
    logic signed [Q_W-1:0]    sq_reg;

    // Result registers.
    logic                     res_ok_reg;
    logic [BIN_W-1:0]         res_bin_reg;
    logic [CNT_W-1:0]         res_count_reg;
    logic signed [SUM_W-1:0]  res_re_reg;
    logic signed [SUM_W-1:0]  res_im_reg;
    logic                     m_valid_reg;
    logic [119:0]             m_data_reg;
    logic                     m_user_reg;

    // Stores.
    logic [CNT_W-1:0]         cnt_mem [CNT_DEPTH];
    logic signed [SUM_W-1:0]  cos_mem [SUM_DEPTH];
    logic signed [SUM_W-1:0]  sin_mem [SUM_DEPTH];
    logic [CNT_W-1:0]         cnt_rd_reg;
    logic signed [SUM_W-1:0]  cos_rd_reg;
    logic signed [SUM_W-1:0]  sin_rd_reg;

    // Combinational helpers.
    logic                     s_fire;
    logic                     cfg_write;
    logic signed [PT_W-1:0]   mul_op;
    logic signed [SQ_W-1:0]   mul_prod;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         rem_trial;
    logic [DIV_W-1:0]         div_trial;
    logic [PT_W-1:0]          pt_diff;
    logic                     sample_ok;
    logic [BIN_W-1:0]         cur_bin;
    logic [H_W-1:0]           cur_h;
    logic [CNT_AW-1:0]        cnt_addr;
    logic [SUM_AW-1:0]        sum_addr;
    logic                     mem_clear;
    logic                     hwr_we;
    logic [CNT_W-1:0]         cnt_new;
    logic signed [SUM_W-1:0]  cos_new;
    logic signed [SUM_W-1:0]  sin_new;
    logic signed [Q_W:0]      ang_s;
    logic signed [Q_W-1:0]    ang_fold;
    logic                     ang_neg;
    logic                     zero_vec;
    logic                     read_ok;
    logic                     out_load;

    // CORDIC connection.
    cordic_cmd_t              cor_cmd;
    logic signed [XY_W-1:0]   cor_x_in;
    logic signed [XY_W-1:0]   cor_y_in;
    logic [Z_W-1:0]           cor_z_in;
    logic                     cor_done;
    logic signed [XY_W-1:0]   cor_x;
    logic signed [XY_W-1:0]   cor_y;
    logic [Z_W-1:0]           cor_z;
    logic signed [XY_W-1:0]   vx;
    logic signed [XY_W-1:0]   vy;
    logic [Z_W-1:0]           z_round;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_PT_MIN: prdata = 32'(pt_min_reg);
            default:    prdata = 32'(bin_width_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_min_reg    <= '0;
            bin_width_reg <= PT_W'(16384);
        end else if (cfg_write) begin
            if (paddr[2] == REG_PT_MIN) begin
                pt_min_reg <= pwdata[PT_W-1:0];
            end else begin
                bin_width_reg <= pwdata[PT_W-1:0];
            end
        end
    end

    // One multiplier serves both squares.
    assign mul_op   = (state_reg == S_SQX) ? px_reg : py_reg;
    assign mul_prod = mul_op * mul_op;

    // Digit-by-digit square root, two radicand bits per cycle.
    assign rem_sh    = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
    assign rem_trial = (REM_W+2)'({root_reg, 2'b01});

    // Bin range check and restoring division for the quotient bits.
    assign pt_diff   = root_reg - pt_min_reg;
    assign sample_ok = (int'(sp_reg) < NUM_SPECIES) && (bin_width_reg != '0) &&
                       (root_reg >= pt_min_reg) &&
                       (DIV_W'(pt_diff) < {bin_width_reg, {BIN_W{1'b0}}});
    assign div_trial = DIV_W'(bin_width_reg) << div_cnt_reg;

    assign read_ok = (int'(sp_reg) < NUM_SPECIES) && (int'(rb_reg) < NUM_BINS) &&
                     (int'(rh_reg) < NUM_HARMONICS);

    // Store addressing.
    assign cur_bin  = func_reg ? rb_reg : quo_reg;
    assign cur_h    = func_reg ? H_W'(rh_reg) : h_reg;
    assign mem_clear = (state_reg == S_CLEAR);
    assign cnt_addr = mem_clear ? CNT_AW'(clr_reg)
                                : CNT_AW'(int'(sp_reg) * NUM_BINS + int'(cur_bin));
    assign sum_addr = mem_clear ? clr_reg
                                : SUM_AW'((int'(cur_h) * NUM_SPECIES + int'(sp_reg))
                                          * NUM_BINS + int'(cur_bin));

    assign hwr_we  = (state_reg == S_HWR);
    assign cnt_new = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
    assign cos_new = sat_add(cos_rd_reg, cq_reg);
    assign sin_new = sat_add(sin_rd_reg, sq_reg);

    always_ff @(posedge aclk) begin
        if (mem_clear) begin
            cos_mem[sum_addr] <= '0;
            sin_mem[sum_addr] <= '0;
            if (int'(clr_reg) < CNT_DEPTH) begin
                cnt_mem[cnt_addr] <= '0;
            end
        end else if (hwr_we) begin
            cos_mem[sum_addr] <= cos_new;
            sin_mem[sum_addr] <= sin_new;
            if (h_reg == '0) begin
                cnt_mem[cnt_addr] <= cnt_new;
            end
        end
        cnt_rd_reg <= cnt_mem[cnt_addr];
        cos_rd_reg <= cos_mem[sum_addr];
        sin_rd_reg <= sin_mem[sum_addr];
    end

    // Vectoring start: scale by 2^16, turn a left half-plane vector by a half turn.
    assign zero_vec = (px_reg == '0) && (py_reg == '0);
    assign vx       = XY_W'(px_reg) <<< 16;
    assign vy       = XY_W'(py_reg) <<< 16;
    assign z_round  = cor_z + Z_W'(32'h8000);

    // Rotation start: fold the harmonic angle into a quarter turn either side.
    assign ang_s = (Q_W+1)'($signed(ang_reg));
    always_comb begin
        if (ang_s > (Q_W+1)'(16384)) begin
            ang_fold = Q_W'(ang_s - (Q_W+1)'(32768));
            ang_neg  = 1'b1;
        end else if (ang_s < -(Q_W+1)'(16384)) begin
            ang_fold = Q_W'(ang_s + (Q_W+1)'(32768));
            ang_neg  = 1'b1;
        end else begin
            ang_fold = $signed(ang_reg);
            ang_neg  = 1'b0;
        end
    end

    always_comb begin
        cor_cmd  = '0;
        cor_x_in = CORDIC_GAIN;
        cor_y_in = '0;
        cor_z_in = {ang_fold, {(Z_W-Q_W){1'b0}}};
        if (state_reg == S_VEC) begin
            cor_cmd.start     = !zero_vec;
            cor_cmd.vectoring = 1'b1;
            cor_x_in = px_reg[PT_W-1] ? -vx : vx;
            cor_y_in = px_reg[PT_W-1] ? -vy : vy;
            cor_z_in = px_reg[PT_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : '0;
        end else if (state_reg == S_HROT) begin
            cor_cmd.start = 1'b1;
        end
    end

    fha_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cor_cmd),
        .x_in    (cor_x_in),
        .y_in    (cor_y_in),
        .z_in    (cor_z_in),
        .done    (cor_done),
        .x_out   (cor_x),
        .y_out   (cor_y),
        .z_out   (cor_z)
    );

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SUM_AW'(SUM_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= s_tuser ? S_RRD : S_SQX;
                    end
                end
                S_SQX:  state_reg <= S_SQY;
                S_SQY:  state_reg <= S_SQRT;
                S_SQRT: begin
                    if (iter_reg == SQRT_W'(PT_W - 1)) begin
                        state_reg <= S_DCHK;
                    end
                end
                S_DCHK: state_reg <= sample_ok ? S_DIV : S_OUT;
                S_DIV: begin
                    if (div_cnt_reg == '0) begin
                        state_reg <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (int'(quo_reg) >= NUM_BINS) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= zero_vec ? S_HROT : S_VWAIT;
                    end
                end
                S_VWAIT: begin
                    if (cor_done) begin
                        state_reg <= S_HROT;
                    end
                end
                S_HROT:  state_reg <= S_HWAIT;
                S_HWAIT: begin
                    if (cor_done) begin
                        state_reg <= S_HRD;
                    end
                end
                S_HRD: state_reg <= S_HWR;
                S_HWR: begin
                    state_reg <= (int'(h_reg) == NUM_HARMONICS - 1) ? S_OUT : S_HROT;
                end
                S_RRD: state_reg <= read_ok ? S_RWR : S_OUT;
                S_RWR: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                func_reg      <= s_tuser;
                sp_reg        <= s_tdata[3:0];
                px_reg        <= s_tdata[27:4];
                py_reg        <= s_tdata[51:28];
                rb_reg        <= s_tdata[56:52];
                rh_reg        <= s_tdata[59:57];
                res_ok_reg    <= 1'b0;
                res_bin_reg   <= s_tuser ? s_tdata[56:52] : '0;
                res_count_reg <= '0;
                res_re_reg    <= '0;
                res_im_reg    <= '0;
            end
            S_SQX: rad_reg <= mul_prod;
            S_SQY: begin
                rad_reg  <= rad_reg + mul_prod;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            S_SQRT: begin
                rad_reg  <= rad_reg << 2;
                iter_reg <= iter_reg + 1'b1;
                if (rem_sh >= rem_trial) begin
                    rem_reg  <= REM_W'(rem_sh - rem_trial);
                    root_reg <= {root_reg[PT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[PT_W-2:0], 1'b0};
                end
            end
            S_DCHK: begin
                dvd_reg     <= pt_diff;
                quo_reg     <= '0;
                div_cnt_reg <= BD_W'(BIN_W - 1);
            end
            S_DIV: begin
                if (DIV_W'(dvd_reg) >= div_trial) begin
                    dvd_reg              <= PT_W'(DIV_W'(dvd_reg) - div_trial);
                    quo_reg[div_cnt_reg] <= 1'b1;
                end
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            S_VEC: begin
                h_reg   <= '0;
                phi_reg <= '0;
                ang_reg <= '0;
            end
            S_VWAIT: begin
                if (cor_done) begin
                    phi_reg <= z_round[Z_W-1:Z_W-Q_W];
                    ang_reg <= z_round[Z_W-1:Z_W-Q_W];
                end
            end
            S_HROT: neg_reg <= ang_neg;
            S_HWAIT: begin
                if (cor_done) begin
                    cq_reg <= to_q15(cor_x, neg_reg);
                    sq_reg <= to_q15(cor_y, neg_reg);
                end
            end
            S_HWR: begin
                if (h_reg == '0) begin
                    res_count_reg <= cnt_new;
                end
                if (int'(h_reg) == int'(rh_reg)) begin
                    res_re_reg <= cos_new;
                    res_im_reg <= sin_new;
                end
                res_ok_reg  <= 1'b1;
                res_bin_reg <= quo_reg;
                h_reg       <= h_reg + 1'b1;
                ang_reg     <= ang_reg + phi_reg;
            end
            S_RWR: begin
                res_ok_reg    <= 1'b1;
                res_count_reg <= cnt_rd_reg;
                res_re_reg    <= cos_rd_reg;
                res_im_reg    <= sin_rd_reg;
            end
            default: ;
        endcase
    end

    // Output register: holds one result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_user_reg <= res_ok_reg;
            m_data_reg <= {3'b000, res_im_reg, res_re_reg, res_count_reg, res_bin_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    // No input is taken while the stores are being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input ready during clearing pass");

    // The CORDIC only finishes while the sequencer waits for it.
    a_cordic_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_done |-> (state_reg == S_VWAIT || state_reg == S_HWAIT))
        else $error("CORDIC finished outside a wait state");

    // An accepted item always leaves the idle state on the next cycle.
    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for flow_harmonic_accumulator_unit: a scoreboard class
// predicts each result from its own copy of the registers and histograms.
// Depends on rtl/fha_pkg.sv and rtl/flow_harmonic_accumulator_unit.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fha_pkg::*;

    // Selector carried on s_tuser.
    typedef enum bit {
        FUNC_SAMPLE = 1'b0,
        FUNC_READ   = 1'b1
    } func_e;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_PT_MIN    = 3'd0;
    localparam logic [2:0] ADDR_BIN_WIDTH = 3'd4;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct {
        bit                    in_range;
        bit [BIN_W-1:0]        bin;
        bit [CNT_W-1:0]        count;
        bit [SUM_W-1:0]        real_sum;
        bit [SUM_W-1:0]        imag_sum;
    } flow_result_t;

    // The scoreboard keeps the expected histogram contents and the results still
    // owed by the block, oldest first.
    class flow_scoreboard;
        bit [PT_W-1:0]  pt_min;
        bit [PT_W-1:0]  bin_width;
        int unsigned    counts[CNT_DEPTH];
        longint         cos_acc[SUM_DEPTH];
        longint         sin_acc[SUM_DEPTH];
        flow_result_t   owed[$];
        int             errors;
        longint         step_turn[CORDIC_STEPS];

        function new();
            step_turn = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087,
                          667544, 333772, 166886, 83443, 41722,
                          20861, 10430, 5215, 2608, 1304};
            pt_min    = '0;
            bin_width = 24'd16384;
            foreach (counts[i]) counts[i] = 0;
            foreach (cos_acc[i]) begin
                cos_acc[i] = 0;
                sin_acc[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] value);
            if (addr == ADDR_PT_MIN) begin
                pt_min = value[PT_W-1:0];
            end else if (addr == ADDR_BIN_WIDTH) begin
                bin_width = value[PT_W-1:0];
            end
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // Vectoring CORDIC; the angle accumulator wraps at one full turn.
        function bit [15:0] azimuth(longint px, longint py);
            longint  x, y, dx, dy;
            bit [31:0] z, r;
            if (px == 0 && py == 0) return 16'd0;
            x = px * 65536;
            y = py * 65536;
            z = '0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + 32'(step_turn[i]);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - 32'(step_turn[i]);
                end
            end
            r = z + 32'h8000;
            return r[31:16];
        endfunction

        function longint round_q15(longint v, bit neg);
            longint r;
            r = (v + 16384) >>> 15;
            if (neg) r = -r;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        // Rotation CORDIC, angle folded into a quarter turn either side of zero.
        function void harmonic_cos_sin(bit [15:0] angle, output longint c,
                                       output longint s);
            longint a, x, y, z, dx, dy;
            bit     neg;
            a   = longint'(signed'(angle));
            neg = 1'b0;
            if (a > 16384) begin
                a   = a - 32768;
                neg = 1'b1;
            end else if (a < -16384) begin
                a   = a + 32768;
                neg = 1'b1;
            end
            x = 652032874;
            y = 0;
            z = a * 65536;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step_turn[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step_turn[i];
                end
            end
            c = round_q15(x, neg);
            s = round_q15(y, neg);
        endfunction

        function longint sat40(longint v);
            if (v > 64'sd549755813887) return 64'sd549755813887;
            if (v < -64'sd549755813888) return -64'sd549755813888;
            return v;
        endfunction

        function int sum_slot(int h, int sp, int b);
            return (h * NUM_SPECIES + sp) * NUM_BINS + b;
        endfunction

        // Called for every accepted input transfer.
        function void note_input(func_e func, bit [SP_W-1:0] sp,
                                 bit signed [PT_W-1:0] px, bit signed [PT_W-1:0] py,
                                 bit [BIN_W-1:0] rb, bit [HARM_W-1:0] rh);
            flow_result_t      res;
            longint            spx, spy, c, s;
            longint unsigned   mag, b;
            bit [15:0]         phi;
            int                ci, k;
            res = '{default: '0};
            if (func == FUNC_SAMPLE) begin
                spx = px;
                spy = py;
                mag = isqrt(longint'(spx * spx + spy * spy));
                if (bin_width != 0 && mag >= pt_min) begin
                    b = (mag - pt_min) / bin_width;
                    if (b < NUM_BINS) begin
                        phi = azimuth(spx, spy);
                        ci  = sp * NUM_BINS + int'(b);
                        if (counts[ci] != 32'hFFFF_FFFF) counts[ci]++;
                        for (int h = 0; h < NUM_HARMONICS; h++) begin
                            harmonic_cos_sin(16'(phi * (h + 1)), c, s);
                            k = sum_slot(h, sp, int'(b));
                            cos_acc[k] = sat40(cos_acc[k] + c);
                            sin_acc[k] = sat40(sin_acc[k] + s);
                        end
                        res.in_range = 1'b1;
                        res.bin      = b[BIN_W-1:0];
                        res.count    = counts[ci];
                        // An out-of-range harmonic still updates, but reports zero sums.
                        if (rh < NUM_HARMONICS) begin
                            k = sum_slot(rh, sp, int'(b));
                            res.real_sum = cos_acc[k][SUM_W-1:0];
                            res.imag_sum = sin_acc[k][SUM_W-1:0];
                        end
                    end
                end
            end else begin
                res.bin = rb;
                if (rh < NUM_HARMONICS) begin
                    k = sum_slot(rh, sp, rb);
                    res.in_range = 1'b1;
                    res.count    = counts[sp * NUM_BINS + rb];
                    res.real_sum = cos_acc[k][SUM_W-1:0];
                    res.imag_sum = sin_acc[k][SUM_W-1:0];
                end
            end
            owed.push_back(res);
        endfunction

        function void check_result(flow_result_t got);
            flow_result_t want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result transfer, bin %0d count %0d",
                         $time, got.bin, got.count);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (want.in_range != got.in_range) begin
                $display("%0t: in_range expected %0d actual %0d",
                         $time, want.in_range, got.in_range);
                errors++;
            end
            if (want.bin != got.bin) begin
                $display("%0t: bin expected %0d actual %0d", $time, want.bin, got.bin);
                errors++;
            end
            if (want.count != got.count) begin
                $display("%0t: count expected %0d actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
            if (want.real_sum != got.real_sum) begin
                $display("%0t: real_sum expected %h actual %h",
                         $time, want.real_sum, got.real_sum);
                errors++;
            end
            if (want.imag_sum != got.imag_sum) begin
                $display("%0t: imag_sum expected %h actual %h",
                         $time, want.imag_sum, got.imag_sum);
                errors++;
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [63:0]   s_tdata;     // species, px, py, read_bin, read_harmonic, zero fill
    logic          s_tuser;     // func
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;     // bin, count, real_sum, imag_sum, zero fill
    logic          m_tuser;     // in_range
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    flow_harmonic_accumulator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    flow_scoreboard sb = new();
    bit             steady;        // When set, neither side idles.
    int             quiet_cycles;
    int             cfg_errors;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver stalls at random, except during the steady stretch.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= steady || ($urandom_range(0, 99) >= 21);
        end
    end

    // Every accepted result transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result('{in_range: m_tuser, bin: m_tdata[4:0],
                              count: m_tdata[36:5], real_sum: m_tdata[76:37],
                              imag_sum: m_tdata[116:77]});
        end
    end

    // The watchdog allows the clearing pass after reset plus many slow samples.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // One input transfer; an optional gap is inserted first with tvalid low.
    task automatic send_item(func_e func, bit [SP_W-1:0] sp, bit [PT_W-1:0] px,
                             bit [PT_W-1:0] py, bit [BIN_W-1:0] rb,
                             bit [HARM_W-1:0] rh);
        @(negedge aclk);
        if (!steady && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, rh, rb, py, px, sp};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(func, sp, px, py, rb, rh);
    endtask

    // Lower tvalid and hold off until every owed result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write, then a read-back of the same register.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(addr, value);
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[PT_W-1:0] !== value[PT_W-1:0]) begin
            $display("%0t: register %0d read expected %h actual %h",
                     $time, addr, value[PT_W-1:0], prdata[PT_W-1:0]);
            cfg_errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic bit [PT_W-1:0] signed_pick(int unsigned span);
        int signed v;
        v = int'($urandom_range(0, span));
        if ($urandom_range(0, 1)) v = -v;
        return v[PT_W-1:0];
    endfunction

    // Random items: mostly samples aimed at the configured bin range, some over
    // the whole field range, and a quarter reads.
    task automatic random_items(int n);
        longint      reach;
        int unsigned span;
        int          pick;
        reach = longint'(sb.pt_min) + 32 * longint'(sb.bin_width);
        span  = (reach > 5900000) ? 5900000 : int'(reach * 3 / 4);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_item(FUNC_READ, 4'($urandom), 24'($urandom), 24'($urandom),
                          5'($urandom), 3'($urandom));
            end else if (pick < 45) begin
                send_item(FUNC_SAMPLE, 4'($urandom), 24'($urandom), 24'($urandom),
                          5'($urandom), 3'($urandom));
            end else begin
                send_item(FUNC_SAMPLE, 4'($urandom), signed_pick(span),
                          signed_pick(span), 5'($urandom), 3'($urandom));
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = FUNC_SAMPLE;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        steady     = 1'b0;
        cfg_errors = 0;
        quiet_cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset register values.
        send_item(FUNC_READ, 4'd0, '0, '0, 5'd0, 3'd0);
        send_item(FUNC_SAMPLE, 4'd3, '0, '0, 5'd0, 3'd0);          // zero vector
        send_item(FUNC_SAMPLE, 4'd3, 24'd70000, '0, 5'd0, 3'd1);
        send_item(FUNC_SAMPLE, 4'd3, '0, 24'd70000, 5'd0, 3'd2);
        send_item(FUNC_SAMPLE, 4'd3, -24'sd70000, '0, 5'd0, 3'd3);
        send_item(FUNC_SAMPLE, 4'd3, '0, -24'sd70000, 5'd0, 3'd4);
        send_item(FUNC_SAMPLE, 4'd3, -24'sd50000, -24'sd50000, 5'd0, 3'd5);
        send_item(FUNC_SAMPLE, 4'd15, 24'd300000, 24'd200000, 5'd0, 3'd6); // bad harmonic
        send_item(FUNC_SAMPLE, 4'd15, 24'd300000, 24'd200000, 5'd0, 3'd7);
        send_item(FUNC_SAMPLE, 4'd0, 24'h800000, 24'h800000, 5'd0, 3'd0); // most negative
        send_item(FUNC_SAMPLE, 4'd0, 24'h7FFFFF, 24'h7FFFFF, 5'd0, 3'd0); // largest
        send_item(FUNC_SAMPLE, 4'd9, 24'd16383, 24'd0, 5'd0, 3'd0);      // edge of bin 0
        send_item(FUNC_SAMPLE, 4'd9, 24'd16384, 24'd0, 5'd0, 3'd0);
        send_item(FUNC_SAMPLE, 4'd9, 24'd524287, 24'd0, 5'd0, 3'd0);     // top bin
        send_item(FUNC_SAMPLE, 4'd9, 24'd524288, 24'd0, 5'd0, 3'd0);     // just past it
        for (int h = 0; h < 8; h++) begin
            send_item(FUNC_READ, 4'd3, '0, '0, 5'd4, 3'(h));              // includes bad reads
        end
        send_item(FUNC_READ, 4'd15, '0, '0, 5'd31, 3'd5);
        send_item(FUNC_READ, 4'd9, '0, '0, 5'd31, 3'd0);
        random_items(150);

        // Sender holds off mid-stream until everything owed has come back.
        drain();
        random_items(60);
        drain();

        write_reg(ADDR_BIN_WIDTH, 32'd1);
        random_items(150);
        drain();
        write_reg(ADDR_PT_MIN, 32'd1000);
        write_reg(ADDR_BIN_WIDTH, 32'd300);
        send_item(FUNC_SAMPLE, 4'd1, 24'd999, '0, 5'd0, 3'd0);           // below the first edge
        send_item(FUNC_SAMPLE, 4'd1, 24'd1000, '0, 5'd0, 3'd0);
        random_items(150);
        drain();

        // A stretch with no idling on either side.
        steady = 1'b1;
        write_reg(ADDR_PT_MIN, 32'd65536);
        write_reg(ADDR_BIN_WIDTH, 32'd65536);
        random_items(250);
        drain();
        steady = 1'b0;

        write_reg(ADDR_PT_MIN, 32'hFF_FFFF);
        write_reg(ADDR_BIN_WIDTH, 32'hFF_FFFF);
        random_items(120);
        drain();
        write_reg(ADDR_PT_MIN, 32'd0);
        random_items(200);
        drain();
        write_reg(ADDR_PT_MIN, 32'h10_0000);
        write_reg(ADDR_BIN_WIDTH, 32'h2_0000);
        random_items(440);

        drain();
        if (sb.errors == 0 && cfg_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/fha_pkg.sv
rtl/fha_cordic.sv
rtl/flow_harmonic_accumulator_unit.sv
tb/testbench.sv
